// File: hw/rtl/empirical_multivariate_count_unit_assert.svh
// assertion macros for the empirical multivariate count unit
// used by the modules that check their own control logic
`ifndef EMPIRICAL_MULTIVARIATE_COUNT_UNIT_ASSERT_SVH
`define EMPIRICAL_MULTIVARIATE_COUNT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define EMC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define EMC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");

`endif

// File: hw/rtl/emc_pkg.sv
// shared types and constants for the empirical multivariate count unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package emc_pkg;
  localparam int MaxSamplesDefault = 1024;
  localparam int MaxDimsDefault = 4;
  localparam int CoordFields = 4;
  localparam int CountW = 11;
  localparam int FracW = 17;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PDF   = 2'd1,
    MODE_CDF   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [31:0] coord_zero;
    logic signed [31:0] coord_one;
    logic signed [31:0] coord_two;
    logic signed [31:0] coord_three;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] match_count;
    logic [FracW-1:0] fraction;
    logic [CountW-1:0] samples_held;
    logic store_full;
  } out_word_t;

  // control word handed along the chain of cells
  typedef struct packed {
    logic valid;
    logic eq_mode;
    logic ok;
  } cell_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/emc_cell.sv
// one coordinate compare cell of the chain
// depends on emc_pkg
`timescale 1ns / 1ps
`default_nettype none
module emc_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enable,
  input  wire logic [31:0] sample,
  input  wire logic [31:0] query,
  input  wire emc_pkg::cell_ctl_t ctl_in,
  output emc_pkg::cell_ctl_t ctl_out
);
  import emc_pkg::*;
  logic hit;
  always_comb begin
    if (!enable) begin
      hit = 1'b1;
    end else if (ctl_in.eq_mode) begin
      hit = (sample == query);
    end else begin
      hit = ($signed(sample) <= $signed(query));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.eq_mode <= ctl_in.eq_mode;
      ctl_out.ok <= ctl_in.ok & hit;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/emc_div.sv
// restoring divider for the q1.16 fraction, one quotient bit per cycle
// depends on emc_pkg
`timescale 1ns / 1ps
`default_nettype none
module emc_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire logic [emc_pkg::CountW-1:0] num,
  input  wire logic [emc_pkg::CountW-1:0] den,
  output logic done,
  output logic [emc_pkg::FracW-1:0] quot
);
  import emc_pkg::*;
  localparam int NumW = CountW + 16;
  localparam int StepW = $clog2(NumW + 1);
  logic [NumW-1:0] dividend;
  logic [CountW:0] rem;
  logic [StepW-1:0] steps;
  logic busy;
  logic [CountW:0] trial;
  logic [NumW-1:0] q;
  always_comb trial = {rem[CountW-1:0], dividend[NumW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !go && busy && (steps == StepW'(1));
      if (go) begin
        busy <= 1'b1;
        steps <= StepW'(NumW);
        dividend <= {num, 16'd0};
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NumW-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
  always_comb quot = q[FracW-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/empirical_multivariate_count_unit.sv
// empirical multivariate count unit: sample store, compare chain, divider
// load and clear answer in the cycle after they are accepted; a query reads one
// stored row per cycle through the compare cells, then takes 27 divider steps
// load and clear take one word per cycle; a query holds busy, so no new word is
// taken until the query has finished; results cannot be stalled
// rst synchronous: empties the store, dims_in_use to 4, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module empirical_multivariate_count_unit #(
  parameter int MAX_SAMPLES = emc_pkg::MaxSamplesDefault,
  parameter int MAX_DIMS = emc_pkg::MaxDimsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire emc_pkg::in_word_t in_word,
  output logic done,
  output emc_pkg::out_word_t out_word,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import emc_pkg::*;
  `include "empirical_multivariate_count_unit_assert.svh"
  localparam int AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NCell = (MAX_DIMS < CoordFields) ? MAX_DIMS : CoordFields;
  localparam int SW = 32 * NCell;

  logic [2:0] dims_in_use;
  logic [2:0] eff_dims;
  state_t state, state_next;
  logic [CountW-1:0] sample_count, hit_count, rd_idx;
  logic [SW-1:0] mem [MAX_SAMPLES];
  logic [SW-1:0] row_pipe [NCell];
  logic [31:0] qv [CoordFields];
  logic [31:0] qreg [NCell];
  logic eq_mode;
  logic rd_valid;
  cell_ctl_t chain [NCell+1];
  logic div_go, div_done;
  logic [FracW-1:0] quot;
  logic accept, cfg_wr;
  logic room;
  logic in_flight;
  logic done_next;
  out_word_t out_next;

  assign pready = 1'b1;
  assign prdata = {29'd0, dims_in_use};
  assign cfg_wr = psel & penable & pwrite;
  assign accept = start & ~busy;
  assign room = sample_count < CountW'(MAX_SAMPLES);
  assign qv[0] = in_word.coord_zero;
  assign qv[1] = in_word.coord_one;
  assign qv[2] = in_word.coord_two;
  assign qv[3] = in_word.coord_three;

  always_comb begin
    eff_dims = dims_in_use;
    if (dims_in_use == 3'd0) eff_dims = 3'd1;
    if (dims_in_use > 3'(NCell)) eff_dims = 3'(NCell);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 3'd4;
    end else if (cfg_wr && paddr == 2'd0) begin
      dims_in_use <= pwdata[2:0];
    end
  end

  always_comb begin
    in_flight = rd_valid;
    for (int g = 1; g <= NCell; g++) in_flight = in_flight | chain[g].valid;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_word.mode == MODE_PDF || in_word.mode == MODE_CDF)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: if (rd_idx == sample_count) state_next = ST_SCAN;
      ST_SCAN: if (!in_flight) state_next = ST_DIV;
      ST_DIV: if (div_done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    div_go = (state == ST_SCAN) && (state_next == ST_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // row data delayed per cell so each cell sees its own coordinate in step
  always_ff @(posedge clk) begin
    if (accept && in_word.mode == MODE_LOAD && room) begin
      for (int j = 0; j < NCell; j++) begin
        mem[sample_count[AddrW-1:0]][32*j +: 32] <= qv[j];
      end
    end
    row_pipe[0] <= mem[rd_idx[AddrW-1:0]];
    for (int j = 1; j < NCell; j++) row_pipe[j] <= row_pipe[j-1];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < NCell; j++) qreg[j] <= qv[j];
      eq_mode <= (in_word.mode == MODE_PDF);
    end
  end

  assign done_next = (state == ST_DONE) ||
                     (accept && (in_word.mode == MODE_LOAD || in_word.mode == MODE_CLEAR));

  always_comb begin
    out_next = '0;
    if (state == ST_DONE) begin
      out_next.match_count = hit_count;
      out_next.fraction = (sample_count == '0) ? '0 : quot;
      out_next.samples_held = sample_count;
    end else if (in_word.mode == MODE_LOAD) begin
      if (room) begin
        out_next.samples_held = sample_count + 1'b1;
      end else begin
        out_next.samples_held = sample_count;
        out_next.store_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      rd_idx <= '0;
      rd_valid <= 1'b0;
      hit_count <= '0;
      done <= 1'b0;
    end else begin
      done <= done_next;
      rd_valid <= (state == ST_READ) && (rd_idx != sample_count);
      if (accept) begin
        rd_idx <= '0;
      end else if (state == ST_READ && rd_idx != sample_count) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (accept) begin
        hit_count <= '0;
      end else if (chain[NCell].valid && chain[NCell].ok) begin
        hit_count <= hit_count + 1'b1;
      end
      if (done_next) out_word <= out_next;
      if (accept && in_word.mode == MODE_LOAD && room) begin
        sample_count <= sample_count + 1'b1;
      end else if (accept && in_word.mode == MODE_CLEAR) begin
        sample_count <= '0;
      end
    end
  end

  assign chain[0] = '{valid: rd_valid, eq_mode: eq_mode, ok: 1'b1};

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    emc_cell u_cell (
      .clk(clk), .rst(rst),
      .enable(3'(g) < eff_dims),
      .sample(row_pipe[g][32*g +: 32]),
      .query(qreg[g]),
      .ctl_in(chain[g]),
      .ctl_out(chain[g+1])
    );
  end

  emc_div u_div (
    .clk(clk), .rst(rst), .go(div_go),
    .num(hit_count), .den(sample_count),
    .done(div_done), .quot(quot)
  );

  `EMC_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, sample_count <= CountW'(MAX_SAMPLES))
  `EMC_ASSERT_IMP(a_match_bound, clk, rst, 1'b1, hit_count <= sample_count)
  `EMC_ASSERT_NEXT(a_done_idle, clk, rst, state == ST_DONE, done && state == ST_IDLE)
endmodule
`default_nettype wire

// File: sim/empirical_multivariate_count_checker.sv
// checker for the empirical multivariate count unit: predicts every result word
// from accepted command words and register writes; depends on emc_pkg
`timescale 1ns / 1ps
module empirical_multivariate_count_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire emc_pkg::in_word_t in_word,
  input wire logic done,
  input wire emc_pkg::out_word_t out_word,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic pready,
  input wire logic [1:0] paddr,
  input wire logic [31:0] pwdata,
  output int errors,
  output int pending
);
  import emc_pkg::*;

  localparam int Depth = 1024;
  localparam logic [1:0] AddrDims = 2'd0;

  logic [31:0] points [Depth][4];
  int held;
  logic [2:0] dims_reg;
  out_word_t expected_words [$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic out_word_t count_matches(input in_word_t w);
    out_word_t r;
    logic [31:0] q [4];
    int d;
    int m;
    bit ok;
    r = '0;
    q[0] = w.coord_zero;
    q[1] = w.coord_one;
    q[2] = w.coord_two;
    q[3] = w.coord_three;
    if (w.mode == MODE_LOAD) begin
      if (held >= Depth) begin
        r.store_full = 1'b1;
      end else begin
        for (int j = 0; j < 4; j++) points[held][j] = q[j];
        held++;
      end
    end else if (w.mode == MODE_CLEAR) begin
      held = 0;
    end else begin
      d = (dims_reg == 0) ? 1 : ((dims_reg > 4) ? 4 : dims_reg);
      m = 0;
      for (int k = 0; k < held; k++) begin
        ok = 1;
        for (int j = 0; j < d; j++) begin
          if (w.mode == MODE_PDF) begin
            if (points[k][j] != q[j]) ok = 0;
          end else if ($signed(points[k][j]) > $signed(q[j])) begin
            ok = 0;
          end
        end
        if (ok) m++;
      end
      r.match_count = CountW'(m);
      if (held != 0) r.fraction = FracW'((longint'(m) * 65536) / held);
    end
    r.samples_held = CountW'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      held = 0;
      dims_reg = 3'd4;
      errors = 0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_word.match_count != want.match_count)
            report("match_count", out_word.match_count, want.match_count);
          if (out_word.fraction != want.fraction)
            report("fraction", out_word.fraction, want.fraction);
          if (out_word.samples_held != want.samples_held)
            report("samples_held", out_word.samples_held, want.samples_held);
          if (out_word.store_full != want.store_full)
            report("store_full", out_word.store_full, want.store_full);
        end
      end
      if (psel && penable && pwrite && pready && paddr == AddrDims) dims_reg = pwdata[2:0];
      if (start && !busy) expected_words.push_back(count_matches(in_word));
    end
    pending = expected_words.size();
  end
endmodule

// File: sim/empirical_multivariate_count_unit_tb.sv
// testbench top for the empirical multivariate count unit: command words, register
// writes and verdict; depends on emc_pkg and empirical_multivariate_count_checker
`timescale 1ns / 1ps
module empirical_multivariate_count_unit_tb;
  import emc_pkg::*;

  localparam logic [1:0] AddrDims = 2'd0;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  in_word_t in_word = '0;
  logic done;
  out_word_t out_word;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors;
  int pending;
  logic [31:0] pool [8];
  bit calm;

  always #2 clk = ~clk;

  empirical_multivariate_count_unit DUT (.*);

  empirical_multivariate_count_checker u_checker (.*);

  function automatic logic [31:0] pick_coord(input bit narrow);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return narrow ? pool[$urandom_range(0, 7)] : $urandom;
    endcase
  endfunction

  task automatic send(input mode_t m, input logic [31:0] a, input logic [31:0] b,
                      input logic [31:0] c, input logic [31:0] d);
    while (!calm && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= '{mode: m, coord_zero: a, coord_one: b, coord_two: c, coord_three: d};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(input bit narrow);
    int r;
    mode_t m;
    r = $urandom_range(0, 99);
    m = (r < 45) ? MODE_LOAD : (r < 70) ? MODE_PDF : (r < 97) ? MODE_CDF : MODE_CLEAR;
    send(m, pick_coord(narrow), pick_coord(narrow), pick_coord(narrow), pick_coord(narrow));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
  endtask

  task automatic set_dims(input logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrDims;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) pool[i] = $urandom_range(0, 3) << 16;
    pool[6] = 32'hffff_0000;
    pool[7] = 32'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send(MODE_PDF, 0, 0, 0, 0);
    send(MODE_CDF, 0, 0, 0, 0);
    send(MODE_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(MODE_LOAD, 0, 0, 0, 0);
    send(MODE_LOAD, 0, 0, 0, 32'h1);
    send(MODE_PDF, 0, 0, 0, 0);
    send(MODE_CDF, 0, 0, 0, 0);
    send(MODE_CDF, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(MODE_CDF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(MODE_PDF, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(MODE_CDF, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(MODE_PDF, 0, 0, 0, 0);
    set_dims(0);
    send(MODE_LOAD, 5, 6, 7, 8);
    send(MODE_PDF, 5, 0, 0, 0);
    set_dims(7);
    send(MODE_PDF, 5, 6, 7, 8);
    // long run of loads with no idling
    set_dims(1);
    calm = 1;
    for (int i = 0; i < 200; i++) begin
      send(MODE_LOAD, pool[i % 8], $urandom, $urandom, $urandom);
    end
    calm = 0;
    send(MODE_CDF, pool[0], 0, 0, 0);
    send(MODE_PDF, 32'hffff_0000, 0, 0, 0);
    send(MODE_CLEAR, 0, 0, 0, 0);
    // random phases, mostly small stores with narrow coordinates
    for (int phase = 0; phase < 6; phase++) begin
      set_dims(phase == 5 ? 32'hffff_fffa : $urandom_range(1, 4));
      for (int i = 0; i < 60; i++) begin
        calm = (phase == 2 && i < 40);
        send_random(phase != 4);
        if (i == 50) drain();
      end
    end
    calm = 0;
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
